// ===== hdl/ert_pkg.sv =====
// Package for the echo reply tracker: field widths, codes, FSM states and
// the saturating counter helper.
// No dependencies.
package ert_pkg;

    // Default sizing of the duplicate bitmap
    localparam int DUP_WINDOW_DEF  = 1024;
    localparam int BITMAP_WORD_DEF = 32;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int SEQ_W      = 16;
    localparam int SEC_W      = 16;
    localparam int USEC_W     = 20;
    localparam int TRIP_W     = 30;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int REQ_W      = 31;
    localparam int USEC_Q_W   = 14;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Seconds to 100 us units
    localparam logic [13:0] SEC_SCALE = 14'd10000;

    // usec / 100 as multiply by reciprocal, exact for 20-bit inputs
    localparam int          USEC_SHIFT = 27;
    localparam int          USEC_RCP_W = 21;
    localparam logic [USEC_RCP_W-1:0] USEC_RECIP =
        USEC_RCP_W'((64'd1 << USEC_SHIFT) / 100 + 1);

    // Shift and width of the reciprocals used for constant divides of 16-bit values
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 33;

    // Register indexes on the configuration port
    localparam logic REG_REQUEST_COUNT = 1'b0;
    localparam logic REG_PROBE_MODE    = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_START   = 2'd0,
        MODE_SEND    = 2'd1,
        MODE_REPLY   = 2'd2,
        MODE_TIMEOUT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_POS,
        ST_WIDX,
        ST_READ,
        ST_COMMIT
    } t_state;

    // Increment that holds at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// ===== hdl/echo_reply_tracker.sv =====
// Echo reply tracker: sequence issue, duplicate detection and trip statistics.
// Send, reply and timeout words step through ST_DIV, ST_POS, ST_WIDX, ST_READ and
// ST_COMMIT; a new word is taken only once the last has committed its result. Start
// word: result from ST_START, then a bitmap clear of WORD_COUNT words (32 by default)
// over the RAM, one word per cycle, input stalled meanwhile. Reset: synchronous, active
// low; the same bitmap clear runs after reset before the first input word is taken.
module echo_reply_tracker #(
    parameter int DUP_WINDOW  = ert_pkg::DUP_WINDOW_DEF,
    parameter int BITMAP_WORD = ert_pkg::BITMAP_WORD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ert_pkg::MODE_W-1:0]     i_mode,
    input  logic [ert_pkg::SEQ_W-1:0]      i_reply_seq,
    input  logic [ert_pkg::SEC_W-1:0]      i_elapsed_sec,
    input  logic [ert_pkg::USEC_W-1:0]     i_elapsed_usec,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ert_pkg::SEQ_W-1:0]      o_send_seq,
    output logic [ert_pkg::TRIP_W-1:0]     o_trip_time,
    output logic                           o_is_duplicate,
    output logic                           o_target_done,
    output logic [ert_pkg::CNT_W-1:0]      o_sent_total,
    output logic [ert_pkg::CNT_W-1:0]      o_received_total,
    output logic [ert_pkg::CNT_W-1:0]      o_repeat_total,
    output logic [ert_pkg::CNT_W-1:0]      o_min_trip,
    output logic [ert_pkg::CNT_W-1:0]      o_max_trip,
    output logic [ert_pkg::SUM_W-1:0]      o_trip_sum,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ert_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ert_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ert_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import ert_pkg::*;

    localparam int WORD_COUNT = (DUP_WINDOW + BITMAP_WORD - 1) / BITMAP_WORD;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BW         = $clog2(BITMAP_WORD);
    localparam int PW         = $clog2(DUP_WINDOW);
    localparam int Q_MAX      = ((1 << SEQ_W) - 1) / DUP_WINDOW;
    localparam int QW         = (Q_MAX > 0) ? $clog2(Q_MAX + 1) : 1;
    localparam int SEQ_PROD_W = SEQ_W + RECIP_W;
    localparam int POS_PROD_W = PW + RECIP_W;
    localparam int USEC_PROD_W = USEC_W + USEC_RCP_W;

    // Reciprocals for the window and word divides (exact for 16-bit dividends)
    localparam logic [RECIP_W-1:0] SEQ_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DUP_WINDOW + 1);
    localparam logic [RECIP_W-1:0] BIT_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / BITMAP_WORD + 1);

    // FSM and clear sweep
    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    // Captured input word and stage registers
    t_mode                r_mode;
    logic [SEQ_W-1:0]     r_seq;
    logic [SEC_W-1:0]     r_sec;
    logic [USEC_W-1:0]    r_usec;
    logic [QW-1:0]        r_q;
    logic [TRIP_W-1:0]    r_sec_prod;
    logic [USEC_Q_W-1:0]  r_usec_q;
    logic [PW-1:0]        r_pos;
    logic [TRIP_W-1:0]    r_trip;
    logic [AW-1:0]        r_widx;
    logic [BW-1:0]        r_bit;

    // Statistics
    logic [CNT_W-1:0] r_sent, r_recv, r_rep, r_min, r_max;
    logic [CNT_W-1:0] n_sent, n_recv, n_rep, n_min, n_max;
    logic [REQ_W-1:0] r_remain, n_remain;
    logic [SUM_W-1:0] r_sum, n_sum;

    // Configuration
    logic [REQ_W-1:0] r_request_count;
    logic             r_probe_mode;

    // Output register
    logic              r_out_valid;
    logic [SEQ_W-1:0]  r_out_seq;
    logic [TRIP_W-1:0] r_out_trip;
    logic              r_out_dup;
    logic              r_out_done;
    logic              n_dup, n_done;

    // Datapath
    logic [SEQ_PROD_W-1:0]  w_seq_prod;
    logic [SEQ_W:0]         w_qd;
    logic [SEQ_W:0]         w_pos_full;
    logic [POS_PROD_W-1:0]  w_pos_prod;
    logic [PW:0]            w_widx_bw;
    logic [PW:0]            w_bit_full;
    logic [USEC_PROD_W-1:0] w_usec_prod;
    logic [SUM_W:0]         w_sum_add;
    logic [REQ_W-1:0]       w_remain_dec;
    logic                   w_bit_set;
    logic [BITMAP_WORD-1:0] w_mask;

    // Control
    logic                   w_out_free;
    logic                   w_commit;
    logic                   w_cfg_write;
    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_waddr;
    logic [BITMAP_WORD-1:0] w_ram_wdata;
    logic [BITMAP_WORD-1:0] w_ram_rdata;

    // Duplicate bitmap
    ert_ram #(
        .WIDTH (BITMAP_WORD),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_addr (r_widx),
        .o_rd_data (w_ram_rdata)
    );

    // Quotient, window position, word index and bit index
    assign w_seq_prod = SEQ_PROD_W'(r_seq) * SEQ_PROD_W'(SEQ_RECIP);
    assign w_qd       = (SEQ_W + 1)'(r_q) * (SEQ_W + 1)'(DUP_WINDOW);
    assign w_pos_full = (SEQ_W + 1)'(r_seq) - w_qd;
    assign w_pos_prod = POS_PROD_W'(r_pos) * POS_PROD_W'(BIT_RECIP);
    assign w_widx_bw  = (PW + 1)'(r_widx) * (PW + 1)'(BITMAP_WORD);
    assign w_bit_full = (PW + 1)'(r_pos) - w_widx_bw;

    // Elapsed time to trip units
    assign w_usec_prod = USEC_PROD_W'(r_usec) * USEC_PROD_W'(USEC_RECIP);

    // Commit-time arithmetic
    assign w_sum_add    = {1'b0, r_sum} + (SUM_W + 1)'(r_trip);
    assign w_remain_dec = (r_remain != '0) ? r_remain - 1'b1 : '0;
    assign w_bit_set    = w_ram_rdata[r_bit];
    assign w_mask       = BITMAP_WORD'(1) << r_bit;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cfg_write = psel && penable && pwrite && pready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(WORD_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_mode'(i_mode) == MODE_START) ? ST_START : ST_DIV;
                end
            end
            ST_START: begin
                if (w_out_free) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_DIV:  n_state = ST_POS;
            ST_POS:  n_state = ST_WIDX;
            ST_WIDX: n_state = ST_READ;
            ST_READ: n_state = ST_COMMIT;
            ST_COMMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the FSM: handshake, RAM write and next statistics
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_commit    = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_widx;
        w_ram_wdata = w_ram_rdata;
        n_sent      = r_sent;
        n_recv      = r_recv;
        n_rep       = r_rep;
        n_remain    = r_remain;
        n_min       = r_min;
        n_max       = r_max;
        n_sum       = r_sum;
        n_dup       = 1'b0;
        n_done      = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            ST_START: begin
                w_commit = w_out_free;
                n_sent   = '0;
                n_recv   = '0;
                n_rep    = '0;
                n_remain = r_request_count;
                n_min    = '1;
                n_max    = '0;
                n_sum    = '0;
            end
            ST_COMMIT: begin
                w_commit = w_out_free;
                case (r_mode)
                    MODE_SEND: begin
                        w_ram_we    = w_out_free;
                        w_ram_wdata = w_ram_rdata & ~w_mask;
                        n_sent      = sat_inc(r_sent);
                    end
                    MODE_REPLY: begin
                        w_ram_we    = w_out_free;
                        w_ram_wdata = w_ram_rdata | w_mask;
                        n_sum       = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
                        if (CNT_W'(r_trip) < r_min) begin
                            n_min = CNT_W'(r_trip);
                        end
                        if (CNT_W'(r_trip) > r_max) begin
                            n_max = CNT_W'(r_trip);
                        end
                        if (w_bit_set) begin
                            n_rep = sat_inc(r_rep);
                            n_dup = 1'b1;
                        end else begin
                            n_recv   = sat_inc(r_recv);
                            n_remain = w_remain_dec;
                            n_done   = (w_remain_dec == '0) || r_probe_mode;
                        end
                    end
                    MODE_TIMEOUT: begin
                        n_remain = w_remain_dec;
                        n_done   = (w_remain_dec == '0);
                    end
                    default: begin
                        n_remain = r_remain;
                    end
                endcase
            end
            default: begin
                w_commit = 1'b0;
            end
        endcase
    end

    // FSM, clear sweep and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_sent     <= '0;
            r_recv     <= '0;
            r_rep      <= '0;
            r_remain   <= '0;
            r_min      <= '1;
            r_max      <= '0;
            r_sum      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= (r_clr_addr == AW'(WORD_COUNT - 1)) ? '0 : r_clr_addr + 1'b1;
            end
            if (w_commit) begin
                r_sent   <= n_sent;
                r_recv   <= n_recv;
                r_rep    <= n_rep;
                r_remain <= n_remain;
                r_min    <= n_min;
                r_max    <= n_max;
                r_sum    <= n_sum;
            end
        end
    end

    // Capture the input word and advance the datapath stages
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_mode <= t_mode'(i_mode);
            r_seq  <= (t_mode'(i_mode) == MODE_SEND) ? r_sent[SEQ_W-1:0] + 1'b1
                                                     : i_reply_seq;
            r_sec  <= i_elapsed_sec;
            r_usec <= i_elapsed_usec;
        end
        if (r_state == ST_DIV) begin
            r_q        <= w_seq_prod[RECIP_SHIFT +: QW];
            r_sec_prod <= TRIP_W'(r_sec) * TRIP_W'(SEC_SCALE);
            r_usec_q   <= w_usec_prod[USEC_SHIFT +: USEC_Q_W];
        end
        if (r_state == ST_POS) begin
            r_pos  <= w_pos_full[PW-1:0];
            r_trip <= r_sec_prod + TRIP_W'(r_usec_q);
        end
        if (r_state == ST_WIDX) begin
            r_widx <= w_pos_prod[RECIP_SHIFT +: AW];
        end
        if (r_state == ST_READ) begin
            r_bit <= w_bit_full[BW-1:0];
        end
    end

    // Output register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_seq  <= (r_state == ST_COMMIT && r_mode == MODE_SEND) ? r_seq : '0;
            r_out_trip <= (r_state == ST_COMMIT && r_mode == MODE_REPLY) ? r_trip : '0;
            r_out_dup  <= n_dup;
            r_out_done <= n_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_send_seq       = r_out_seq;
    assign o_trip_time      = r_out_trip;
    assign o_is_duplicate   = r_out_dup;
    assign o_target_done    = r_out_done;
    assign o_sent_total     = r_sent;
    assign o_received_total = r_recv;
    assign o_repeat_total   = r_rep;
    assign o_min_trip       = r_min;
    assign o_max_trip       = r_max;
    assign o_trip_sum       = r_sum;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_count <= REQ_W'(4);
            r_probe_mode    <= 1'b0;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_REQUEST_COUNT: r_request_count <= pwdata[REQ_W-1:0];
                REG_PROBE_MODE:    r_probe_mode    <= pwdata[0];
                default:           r_probe_mode    <= r_probe_mode;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_REQUEST_COUNT: prdata = APB_DATA_W'(r_request_count);
            REG_PROBE_MODE:    prdata = APB_DATA_W'(r_probe_mode);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

// ===== hdl/ert_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ert_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
